### rtl/quoted_command_line_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef QUOTED_COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QCLT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define QCLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/qclt_pkg.sv
// Types, codes and constants of the quoted command-line tokenizer.
package qclt_pkg;

   localparam int COUNT_BITS = 8;
   // counts saturate at min(2^COUNT_BITS - 1, 255)
   localparam int COUNT_W    = (COUNT_BITS < 8) ? COUNT_BITS : 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int RES_MAX = 3;

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_TEND = 2'd1;
   localparam logic [1:0] KIND_LINE = 2'd2;

   localparam logic [1:0] COND_NONE = 2'd0;
   localparam logic [1:0] COND_AMP  = 2'd1;
   localparam logic [1:0] COND_QM   = 2'd2;

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_AMP   = 7'h26;
   localparam logic [6:0] CH_QM    = 7'h3F;
   localparam logic [6:0] CH_HASH  = 7'h23;
   localparam logic [6:0] CH_DQ    = 7'h22;
   localparam logic [6:0] CH_SQ    = 7'h27;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_GAP,
      MODE_WORD,
      MODE_DQ,
      MODE_SQ,
      MODE_CMT
   } mode_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] char_out;
      logic [7:0] spaces_before;
      logic [1:0] cond_code;
      logic [7:0] token_total;
   } rsp_type;

   typedef struct packed {
      mode_type           mode;
      logic [COUNT_W-1:0] pending_spaces;
      logic               has_chars;
      logic [1:0]         cond_seen;
      logic [COUNT_W-1:0] token_count;
   } state_type;

   // results caused by one item
   typedef struct packed {
      rsp_type [RES_MAX-1:0] item;
      logic [1:0]            count;
   } bundle_type;

endpackage

### rtl/qclt_step.sv
// Per-item scanner: next tokenizer state and the results one byte causes.
module qclt_step (
   input  qclt_pkg::req_type    req,
   input  qclt_pkg::state_type  state,
   output qclt_pkg::state_type  state_next,
   output qclt_pkg::bundle_type bundle
);

   logic [6:0]          c;
   logic                do_start;
   qclt_pkg::state_type st;
   qclt_pkg::bundle_type b;

   always_comb begin
      c = req.byte_in[6:0];
      if (c < 7'd32) begin
         c = qclt_pkg::CH_SPACE;
      end
      st       = state;
      b        = '0;
      do_start = 1'b0;

      case (st.mode)
         qclt_pkg::MODE_GAP: begin
            do_start = 1'b1;
         end
         qclt_pkg::MODE_WORD: begin
            if (c == qclt_pkg::CH_SPACE || c == qclt_pkg::CH_HASH) begin
               b.item[b.count].kind = qclt_pkg::KIND_TEND;
               b.count = b.count + 2'd1;
               if (st.token_count < qclt_pkg::COUNT_MAX) begin
                  st.token_count = st.token_count + 1'b1;
               end
               st.pending_spaces = '0;
               st.has_chars      = 1'b0;
               st.mode = (c == qclt_pkg::CH_HASH) ? qclt_pkg::MODE_CMT : qclt_pkg::MODE_GAP;
            end else begin
               b.item[b.count].kind     = qclt_pkg::KIND_CHAR;
               b.item[b.count].char_out = c;
               b.count = b.count + 2'd1;
            end
         end
         qclt_pkg::MODE_DQ, qclt_pkg::MODE_SQ: begin
            if ((st.mode == qclt_pkg::MODE_DQ && c == qclt_pkg::CH_DQ) ||
                (st.mode == qclt_pkg::MODE_SQ && c == qclt_pkg::CH_SQ)) begin
               b.item[b.count].kind = qclt_pkg::KIND_TEND;
               b.count = b.count + 2'd1;
               if (st.token_count < qclt_pkg::COUNT_MAX) begin
                  st.token_count = st.token_count + 1'b1;
               end
               st.pending_spaces = '0;
               st.has_chars      = 1'b0;
               st.mode           = qclt_pkg::MODE_GAP;
            end else if (c == qclt_pkg::CH_SPACE) begin
               // leading spaces of a quoted token are dropped
               if (st.has_chars && st.pending_spaces < qclt_pkg::COUNT_MAX) begin
                  st.pending_spaces = st.pending_spaces + 1'b1;
               end
            end else begin
               b.item[b.count].kind          = qclt_pkg::KIND_CHAR;
               b.item[b.count].char_out      = c;
               b.item[b.count].spaces_before = 8'(st.pending_spaces);
               b.count = b.count + 2'd1;
               st.pending_spaces = '0;
               st.has_chars      = 1'b1;
            end
         end
         qclt_pkg::MODE_CMT: begin
         end
         default: begin
            // line start, and any unused mode code
            st.mode = qclt_pkg::MODE_START;
            if (c == qclt_pkg::CH_AMP) begin
               st.cond_seen = qclt_pkg::COND_AMP;
               st.mode      = qclt_pkg::MODE_GAP;
            end else if (c == qclt_pkg::CH_QM) begin
               st.cond_seen = qclt_pkg::COND_QM;
               st.mode      = qclt_pkg::MODE_GAP;
            end else if (c != qclt_pkg::CH_SPACE) begin
               do_start = 1'b1;
            end
         end
      endcase

      if (do_start) begin
         st.pending_spaces = '0;
         st.has_chars      = 1'b0;
         if (c == qclt_pkg::CH_DQ) begin
            st.mode = qclt_pkg::MODE_DQ;
         end else if (c == qclt_pkg::CH_SQ) begin
            st.mode = qclt_pkg::MODE_SQ;
         end else if (c == qclt_pkg::CH_HASH) begin
            st.mode = qclt_pkg::MODE_CMT;
         end else if (c != qclt_pkg::CH_SPACE) begin
            st.mode      = qclt_pkg::MODE_WORD;
            st.has_chars = 1'b1;
            b.item[b.count].kind     = qclt_pkg::KIND_CHAR;
            b.item[b.count].char_out = c;
            b.count = b.count + 2'd1;
         end
      end

      if (req.last_byte) begin
         // an open token ends with the line
         if (st.mode inside {qclt_pkg::MODE_WORD, qclt_pkg::MODE_DQ, qclt_pkg::MODE_SQ}) begin
            b.item[b.count].kind = qclt_pkg::KIND_TEND;
            b.count = b.count + 2'd1;
            if (st.token_count < qclt_pkg::COUNT_MAX) begin
               st.token_count = st.token_count + 1'b1;
            end
         end
         b.item[b.count].kind        = qclt_pkg::KIND_LINE;
         b.item[b.count].cond_code   = st.cond_seen;
         b.item[b.count].token_total = 8'(st.token_count);
         b.count = b.count + 2'd1;
         st = '{mode: qclt_pkg::MODE_START, default: '0};
      end
   end

   assign state_next = st;
   assign bundle     = b;

endmodule

### rtl/quoted_command_line_tokenizer_top.sv
// Top level of the quoted command-line tokenizer.
//
// Input channel req_: one command-line byte per item (byte_in, last_byte),
// accepted on a clock edge with req_valid high and req_stall low.
// Result channel rsp_: one token character, token end or line end per item,
// taken on a clock edge with rsp_valid high and rsp_stall low.
// Each input byte causes zero to three results, in line order.
//
// An accepted byte is held in the input register, where the scanner works on
// it; once the result register is free, the byte's results, if any, move into
// that register, which shows the first of them.
// Throughput: one byte per clock while each byte causes at most one result
// and the receiver does not stall. A byte with more results holds the result
// register until each of its results is taken, and the input register behind it waits.
// The result register is the only thing that sets this figure.
//
// Reset (synchronous, active high) empties both registers and returns the
// scanner to line start with zero counts. When the receiver stalls, the shown
// result holds, one more byte is taken into the input register if it is
// empty, and then req_stall rises until the result register frees.
`include "quoted_command_line_tokenizer_top_defines.svh"

module quoted_command_line_tokenizer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qclt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qclt_pkg::rsp_type rsp_data
);

   logic                 s1_valid_ff, s1_valid_in;
   qclt_pkg::req_type    s1_data_ff;
   qclt_pkg::state_type  state_ff, state_in;
   logic                 s2_valid_ff, s2_valid_in;
   qclt_pkg::bundle_type s2_bundle_ff, bundle;
   logic [1:0]           s2_idx_ff, s2_idx_in;

   logic req_accept, s2_take, s2_done, s2_free, s1_adv;

   qclt_step u_step (
      .req        (s1_data_ff),
      .state      (state_ff),
      .state_next (state_in),
      .bundle     (bundle)
   );

   assign s2_take    = s2_valid_ff && !rsp_stall;
   assign s2_done    = s2_take && (s2_idx_ff == 2'(s2_bundle_ff.count - 2'd1));
   assign s2_free    = !s2_valid_ff || s2_done;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign req_stall  = s1_valid_ff && !s2_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_idx_in   = s2_idx_ff;
      if (s1_adv) begin
         // a byte with no results only moves the scanner state
         s2_valid_in = (bundle.count != 2'd0);
         s2_idx_in   = 2'd0;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end else if (s2_take) begin
         s2_idx_in = s2_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_idx_ff   <= 2'd0;
         state_ff    <= '{mode: qclt_pkg::MODE_START, default: '0};
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_idx_ff   <= s2_idx_in;
         if (s1_adv) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv) begin
         s2_bundle_ff <= bundle;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_bundle_ff.item[s2_idx_ff];

   `QCLT_ASSERT_NOW(a_idx_in_range, s2_valid_ff, s2_idx_ff < s2_bundle_ff.count,
      "result index beyond bundle count")
   `QCLT_ASSERT_NOW(a_line_end_last, s2_valid_ff && rsp_data.kind == qclt_pkg::KIND_LINE,
      s2_idx_ff == 2'(s2_bundle_ff.count - 2'd1), "line end is not the last result of its item")
   `QCLT_ASSERT_NEXT(a_bundle_continues, s2_take && !s2_done, rsp_valid,
      "remaining results of an item were dropped")
   `QCLT_ASSERT_NOW(a_stall_only_full, req_stall, s1_valid_ff && s2_valid_ff,
      "input stalled with a free stage")

endmodule

### bench/quoted_command_line_tokenizer_top_test.sv
// Self-checking bench for the tokenizer: directed byte table, then random lines.
module quoted_command_line_tokenizer_top_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 256;
   localparam logic [7:0] SAT    = 8'(qclt_pkg::COUNT_MAX);

   typedef struct packed {
      qclt_pkg::req_type       req;
      logic                    typed;
      logic [1:0]              n;
      qclt_pkg::rsp_type [2:0] res;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   qclt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   qclt_pkg::rsp_type rsp_data;

   // scanner copy
   qclt_pkg::mode_type tok_mode = qclt_pkg::MODE_START;
   logic [7:0]         pend_sp = '0;
   logic               tok_has = 1'b0;
   logic [1:0]         cond_mark = qclt_pkg::COND_NONE;
   logic [7:0]         tok_cnt = '0;

   qclt_pkg::rsp_type byte_events[$];
   qclt_pkg::rsp_type token_events[$];
   qclt_pkg::req_type line_q[$];
   dir_row_type       dir_rows[$];

   int  mismatches = 0;
   int  idle_cycles = 0;
   int  bytes_sent = 0;
   int  stall_left = 0;
   int  free_left = 0;
   bit  calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quoted_command_line_tokenizer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic qclt_pkg::rsp_type mk_rsp(input logic [1:0] kind, input logic [6:0] ch,
                                                input logic [7:0] sp, input logic [1:0] cond,
                                                input logic [7:0] tot);
      qclt_pkg::rsp_type r;
      r.kind          = kind;
      r.char_out      = ch;
      r.spaces_before = sp;
      r.cond_code     = cond;
      r.token_total   = tot;
      return r;
   endfunction

   function automatic qclt_pkg::req_type mk_req(input logic [7:0] b, input logic last);
      qclt_pkg::req_type r;
      r.byte_in   = b;
      r.last_byte = last;
      return r;
   endfunction

   task automatic emit(input logic [1:0] kind, input logic [6:0] ch, input logic [7:0] sp,
                       input logic [1:0] cond, input logic [7:0] tot);
      byte_events.push_back(mk_rsp(kind, ch, sp, cond, tot));
   endtask

   task automatic close_token();
      emit(qclt_pkg::KIND_TEND, '0, '0, qclt_pkg::COND_NONE, '0);
      if (tok_cnt < SAT) tok_cnt++;
      pend_sp  = '0;
      tok_has  = 1'b0;
      tok_mode = qclt_pkg::MODE_GAP;
   endtask

   task automatic open_word(input logic [6:0] c);
      pend_sp = '0;
      tok_has = 1'b0;
      if (c == qclt_pkg::CH_DQ) begin
         tok_mode = qclt_pkg::MODE_DQ;
      end else if (c == qclt_pkg::CH_SQ) begin
         tok_mode = qclt_pkg::MODE_SQ;
      end else if (c == qclt_pkg::CH_HASH) begin
         tok_mode = qclt_pkg::MODE_CMT;
      end else if (c != qclt_pkg::CH_SPACE) begin
         tok_mode = qclt_pkg::MODE_WORD;
         tok_has  = 1'b1;
         emit(qclt_pkg::KIND_CHAR, c, '0, qclt_pkg::COND_NONE, '0);
      end
   endtask

   // events caused by one byte land in byte_events
   task automatic tokenize_byte(input qclt_pkg::req_type r);
      logic [6:0] c;
      c = r.byte_in[6:0];
      if (c < 7'd32) c = qclt_pkg::CH_SPACE;
      byte_events.delete();
      case (tok_mode)
         qclt_pkg::MODE_GAP: open_word(c);
         qclt_pkg::MODE_WORD: begin
            if (c == qclt_pkg::CH_SPACE) begin
               close_token();
            end else if (c == qclt_pkg::CH_HASH) begin
               close_token();
               tok_mode = qclt_pkg::MODE_CMT;
            end else begin
               emit(qclt_pkg::KIND_CHAR, c, '0, qclt_pkg::COND_NONE, '0);
            end
         end
         qclt_pkg::MODE_DQ, qclt_pkg::MODE_SQ: begin
            if ((tok_mode == qclt_pkg::MODE_DQ && c == qclt_pkg::CH_DQ) ||
                (tok_mode == qclt_pkg::MODE_SQ && c == qclt_pkg::CH_SQ)) begin
               close_token();
            end else if (c == qclt_pkg::CH_SPACE) begin
               // spaces only count once the token has a character
               if (tok_has && pend_sp < SAT) pend_sp++;
            end else begin
               emit(qclt_pkg::KIND_CHAR, c, pend_sp, qclt_pkg::COND_NONE, '0);
               pend_sp = '0;
               tok_has = 1'b1;
            end
         end
         qclt_pkg::MODE_CMT: ;
         default: begin
            if (c == qclt_pkg::CH_AMP) begin
               cond_mark = qclt_pkg::COND_AMP;
               tok_mode  = qclt_pkg::MODE_GAP;
            end else if (c == qclt_pkg::CH_QM) begin
               cond_mark = qclt_pkg::COND_QM;
               tok_mode  = qclt_pkg::MODE_GAP;
            end else if (c != qclt_pkg::CH_SPACE) begin
               open_word(c);
            end
         end
      endcase
      if (r.last_byte) begin
         if (tok_mode == qclt_pkg::MODE_WORD || tok_mode == qclt_pkg::MODE_DQ ||
             tok_mode == qclt_pkg::MODE_SQ) close_token();
         emit(qclt_pkg::KIND_LINE, '0, '0, cond_mark, tok_cnt);
         tok_mode  = qclt_pkg::MODE_START;
         pend_sp   = '0;
         tok_has   = 1'b0;
         cond_mark = qclt_pkg::COND_NONE;
         tok_cnt   = '0;
      end
   endtask

   function automatic int next_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_item(input qclt_pkg::req_type r, input logic use_typed,
                            input logic [1:0] n_typed,
                            input qclt_pkg::rsp_type [2:0] typed_res);
      int gap;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_byte(r);
      if (use_typed) begin
         for (int i = 0; i < n_typed; i++) token_events.push_back(typed_res[i]);
      end else begin
         foreach (byte_events[i]) token_events.push_back(byte_events[i]);
      end
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line();
      calm = ($urandom_range(0, 4) == 0);
      foreach (line_q[i]) begin
         send_item(line_q[i], 1'b0, 2'd0, '0);
         bytes_sent++;
      end
   endtask

   task automatic add_row(input logic [7:0] b, input logic last);
      dir_row_type row;
      row     = '0;
      row.req = mk_req(b, last);
      dir_rows.push_back(row);
   endtask

   task automatic add_typed(input logic [7:0] b, input logic last, input logic [1:0] n,
                            input qclt_pkg::rsp_type r0, input qclt_pkg::rsp_type r1,
                            input qclt_pkg::rsp_type r2);
      dir_row_type row;
      row        = '0;
      row.req    = mk_req(b, last);
      row.typed  = 1'b1;
      row.n      = n;
      row.res[0] = r0;
      row.res[1] = r1;
      row.res[2] = r2;
      dir_rows.push_back(row);
   endtask

   // bytes that clean to a space: plain, control codes, high control codes, high-bit space
   function automatic logic [7:0] blank_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return {1'b0, qclt_pkg::CH_SPACE};
      if (r < 75) return 8'($urandom_range(0, 31));
      if (r < 90) return 8'($urandom_range(128, 159));
      return {1'b1, qclt_pkg::CH_SPACE};
   endfunction

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 8'($urandom_range(33, 126));
      if (r < 92) return 8'($urandom_range(161, 254));
      return $urandom_range(0, 1) ? 8'h7F : 8'hFF;
   endfunction

   task automatic build_line();
      int nw;
      int kind;
      logic [7:0] quote;
      line_q.delete();
      repeat ($urandom_range(0, 2)) line_q.push_back(mk_req(blank_byte(), 1'b0));
      if ($urandom_range(0, 3) == 0)
         line_q.push_back(mk_req({1'($urandom_range(0, 1)),
                                  $urandom_range(0, 1) ? qclt_pkg::CH_AMP : qclt_pkg::CH_QM},
                                 1'b0));
      nw = $urandom_range(0, 5);
      for (int w = 0; w < nw; w++) begin
         if (w > 0 || $urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) line_q.push_back(mk_req(blank_byte(), 1'b0));
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            repeat ($urandom_range(1, 6)) line_q.push_back(mk_req(text_byte(), 1'b0));
         end else if (kind < 9) begin
            quote = {1'($urandom_range(0, 1)),
                     (kind < 7) ? qclt_pkg::CH_DQ : qclt_pkg::CH_SQ};
            line_q.push_back(mk_req(quote, 1'b0));
            repeat ($urandom_range(0, 8))
               line_q.push_back(mk_req(($urandom_range(0, 2) == 0) ? blank_byte() : text_byte(),
                                       1'b0));
            // the last word is sometimes left open
            if (w < nw - 1 || $urandom_range(0, 3) != 0) line_q.push_back(mk_req(quote, 1'b0));
         end else begin
            line_q.push_back(mk_req({1'b0, qclt_pkg::CH_HASH}, 1'b0));
            repeat ($urandom_range(0, 4)) line_q.push_back(mk_req(text_byte(), 1'b0));
         end
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) line_q.push_back(mk_req(blank_byte(), 1'b0));
      if (line_q.size() == 0) line_q.push_back(mk_req(text_byte(), 1'b0));
      line_q[line_q.size()-1].last_byte = 1'b1;
   endtask

   task automatic build_noise();
      line_q.delete();
      repeat ($urandom_range(1, 8))
         line_q.push_back(mk_req(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0)));
      line_q[line_q.size()-1].last_byte = 1'b1;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // receiver stalls: short bursts, a few long ones, and quiet stretches
   always @(posedge clock) begin : rsp_stall_gen
      int r;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (free_left > 0) begin
         rsp_stall <= 1'b0;
         free_left--;
      end else begin
         r = $urandom_range(0, 99);
         free_left  = (r < 20) ? $urandom_range(20, 80) : $urandom_range(0, 3);
         r = $urandom_range(0, 99);
         stall_left = (r < 85) ? $urandom_range(1, 2) : $urandom_range(10, 40);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_check
      qclt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_events.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, rsp_data);
            mismatches++;
         end else begin
            want = token_events.pop_front();
            check_field("kind", want.kind, rsp_data.kind);
            check_field("char_out", want.char_out, rsp_data.char_out);
            check_field("spaces_before", want.spaces_before, rsp_data.spaces_before);
            check_field("cond_code", want.cond_code, rsp_data.cond_code);
            check_field("token_total", want.token_total, rsp_data.token_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // conditional mark, mid-word quote, quoted hash, high byte with inner spaces, comment
      add_typed(8'h00, 1'b0, 2'd0, '0, '0, '0);
      add_typed({1'b0, qclt_pkg::CH_AMP}, 1'b0, 2'd0, '0, '0, '0);
      add_typed(8'h80, 1'b0, 2'd0, '0, '0, '0);
      add_row(8'h61, 1'b0);
      add_row({1'b0, qclt_pkg::CH_DQ}, 1'b0);
      add_row(8'h09, 1'b0);
      add_row({1'b0, qclt_pkg::CH_DQ}, 1'b0);
      add_row({1'b0, qclt_pkg::CH_SPACE}, 1'b0);
      add_row({1'b0, qclt_pkg::CH_HASH}, 1'b0);
      add_row({1'b0, qclt_pkg::CH_SPACE}, 1'b0);
      add_row(8'h1F, 1'b0);
      add_typed(8'hFF, 1'b0, 2'd1,
                mk_rsp(qclt_pkg::KIND_CHAR, 7'h7F, 8'd2, qclt_pkg::COND_NONE, 8'd0), '0, '0);
      add_row({1'b0, qclt_pkg::CH_DQ}, 1'b0);
      add_row(8'h62, 1'b0);
      add_row({1'b0, qclt_pkg::CH_HASH}, 1'b0);
      add_typed(8'h71, 1'b1, 2'd1,
                mk_rsp(qclt_pkg::KIND_LINE, '0, '0, qclt_pkg::COND_AMP, 8'd3), '0, '0);
      // question mark alone on a line
      add_typed({1'b0, qclt_pkg::CH_QM}, 1'b1, 2'd1,
                mk_rsp(qclt_pkg::KIND_LINE, '0, '0, qclt_pkg::COND_QM, 8'd0), '0, '0);
      // empty single quotes still make a token
      add_row({1'b0, qclt_pkg::CH_SQ}, 1'b0);
      add_typed({1'b0, qclt_pkg::CH_SQ}, 1'b1, 2'd2,
                mk_rsp(qclt_pkg::KIND_TEND, '0, '0, qclt_pkg::COND_NONE, 8'd0),
                mk_rsp(qclt_pkg::KIND_LINE, '0, '0, qclt_pkg::COND_NONE, 8'd1), '0);
      // one byte line: character, token end, line end
      add_typed(8'h78, 1'b1, 2'd3,
                mk_rsp(qclt_pkg::KIND_CHAR, 7'h78, '0, qclt_pkg::COND_NONE, 8'd0),
                mk_rsp(qclt_pkg::KIND_TEND, '0, '0, qclt_pkg::COND_NONE, 8'd0),
                mk_rsp(qclt_pkg::KIND_LINE, '0, '0, qclt_pkg::COND_NONE, 8'd1));
      // quote left open at line end
      add_row({1'b0, qclt_pkg::CH_DQ}, 1'b0);
      add_row(8'h6B, 1'b1);
      // comment from the start hides a later mark
      add_typed({1'b0, qclt_pkg::CH_HASH}, 1'b0, 2'd0, '0, '0, '0);
      add_typed({1'b0, qclt_pkg::CH_AMP}, 1'b1, 2'd1,
                mk_rsp(qclt_pkg::KIND_LINE, '0, '0, qclt_pkg::COND_NONE, 8'd0), '0, '0);

      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].n,
                                      dir_rows[i].res);

      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 85) build_line();
         else build_noise();
         send_line();
      end
      req_valid <= 1'b0;

      while (token_events.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### quoted_command_line_tokenizer_top.f
+incdir+rtl
rtl/qclt_pkg.sv
rtl/qclt_step.sv
rtl/quoted_command_line_tokenizer_top.sv
bench/quoted_command_line_tokenizer_top_test.sv
